@@ src/bfmcg_pkg.sv @@
// ----------------------------------------------------------------------------
// Box filter mip chain generator package
// Shared constants, pixel types and the rounding helper.
// ----------------------------------------------------------------------------
package bfmcg_pkg;

	localparam int MAX_DIM_DEF    = 4096;
	localparam int MAX_LEVELS_DEF = 12;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 13;

	localparam logic [CFG_INDEX_W-1:0] REG_BASE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_HEIGHT = 2'd1;

	localparam int CH_W        = 8;
	localparam int PAIR_W      = 9;
	localparam int TOT_W       = 10;
	localparam int LEVEL_W     = 4;
	localparam int POS_W       = 11;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 64;

	typedef struct packed {
		logic [CH_W-1:0] alpha;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pix_t;

	typedef struct packed {
		logic [PAIR_W-1:0] a;
		logic [PAIR_W-1:0] r;
		logic [PAIR_W-1:0] g;
		logic [PAIR_W-1:0] b;
	} pair_t;

	typedef struct packed {
		logic [TOT_W-1:0] a;
		logic [TOT_W-1:0] r;
		logic [TOT_W-1:0] g;
		logic [TOT_W-1:0] b;
	} tot_t;

	// Rounded mean of a four-pixel sum.
	function automatic logic [CH_W-1:0] round_mean(input logic [TOT_W-1:0] tot);
		logic [TOT_W-1:0] s;
		s = tot + TOT_W'(2);
		return s[TOT_W-1:2];
	endfunction

endpackage

@@ src/box_filter_mip_chain_generator_top.sv @@
// ----------------------------------------------------------------------------
// Box filter mip chain generator
// Streams a base image in raster order and emits every pixel of the lower
// mip levels (2x2 rounded box filter) as soon as its source block completes.
// ----------------------------------------------------------------------------
//
//  channel   direction  beat contents
//  --------  ---------  -----------------------------------------------------
//  cfg       in         cfg_index (0 base_width, 1 base_height), cfg_data
//  s_axis    in         one base pixel: blue, green, red, alpha
//  m_axis    out        one mip pixel: level, col, row, four means; tlast
//                       marks the final pixel of the whole chain
//
//  An input beat is accepted in the idle state, then walks the shared level
//  unit: a horizontal and a vertical step per mip pixel it completes (0 to
//  MAX_LEVELS of them), then a horizontal step for the level where the walk
//  ends. The vertical step uses the pair row read registered in the
//  horizontal step before it.
//  A stalled m_axis holds the walk in its vertical cycle; one finished
//  result may wait in the output register while the walk goes on.
//  Reset leaves a 1x1 chain (no output). cfg_ready is high only between
//  pixels; a width or height beat clears all position counters and restarts
//  the image.
// ----------------------------------------------------------------------------
module box_filter_mip_chain_generator_top #(
	parameter int MAX_DIM    = bfmcg_pkg::MAX_DIM_DEF,
	parameter int MAX_LEVELS = bfmcg_pkg::MAX_LEVELS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bfmcg_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bfmcg_pkg::CFG_DATA_W-1:0]   cfg_data,
	// base pixel stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// tdata: blue[7:0], green[15:8], red[23:16], alpha[31:24]
	input  logic [bfmcg_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// mip pixel stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// tdata: level[3:0], col[14:4], row[25:15], out_blue[33:26],
	//        out_green[41:34], out_red[49:42], out_alpha[57:50], zero[63:58]
	output logic [bfmcg_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic                               m_axis_tlast   // chain_done
);
	import bfmcg_pkg::*;

	localparam int DIM_W      = $clog2(MAX_DIM + 1);
	localparam int CNT_W      = $clog2(MAX_DIM);
	localparam int NLVL       = MAX_LEVELS + 1;
	localparam int LVL_W      = $clog2(NLVL);
	localparam int PAIR_DEPTH = MAX_DIM + MAX_LEVELS;
	localparam int ADDR_W     = $clog2(PAIR_DEPTH);
	localparam int PAD_W      = OUT_TDATA_W - LEVEL_W - 2 * POS_W - 4 * CH_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HORZ = 2'd1;
	localparam logic [1:0] ST_VERT = 2'd2;

	// Size of a level: base size shifted down, never below one.
	function automatic logic [DIM_W-1:0] dim_at(input logic [DIM_W-1:0] d,
			input logic [LVL_W-1:0] k);
		logic [DIM_W-1:0] s;
		s = d >> k;
		return (s == '0) ? DIM_W'(1) : s;
	endfunction

	// ---------------------------------------------------------------- state
	logic [1:0]        state_q;
	logic [DIM_W-1:0]  w0_q, h0_q;           // clamped base size
	logic [LVL_W-1:0]  k_q;                  // level being walked
	logic [ADDR_W-1:0] off_q;                // pair row base of level k
	pix_t              pix_q;                // pixel fed into level k
	logic [CNT_W-1:0]  col_cnt_q [NLVL];
	logic [CNT_W-1:0]  row_cnt_q [NLVL];
	pix_t              hold_q [NLVL];        // pending even-column pixel
	pair_t             pair_mem [PAIR_DEPTH];
	pair_t             mem_rd_q;

	// horizontal to vertical hand-over
	pair_t             pair_q;
	logic [CNT_W-1:0]  tx_q, ty_q;
	logic              hone_q;

	// output register
	logic              out_valid_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic [POS_W-1:0]  out_col_q, out_row_q;
	pix_t              out_pix_q;
	logic              out_last_q;

	// ---------------------------------------------------------------- config
	logic [31:0]      cfg_v;
	logic [DIM_W-1:0] cfg_dim;
	logic             cfg_wr;

	// take geometry only between pixels
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign cfg_v     = 32'(cfg_data);
	// saturate to the supported range, zero taken as one
	assign cfg_dim   = (cfg_v == 32'd0) ? DIM_W'(1) :
		(cfg_v > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(cfg_v);

	// ---------------------------------------------------------- horizontal
	logic [DIM_W-1:0]  w_cur, h_cur;
	logic              lvl_act, w_one, h_one;
	logic [CNT_W-1:0]  c_cur, r_cur, tx_cur;
	logic              c_last, r_last, h_go, v_go, hold_wr, mem_wr;
	pix_t              hold_cur;
	pair_t             pair_cur;
	logic [ADDR_W-1:0] idx;

	always_comb begin
		w_cur    = dim_at(w0_q, k_q);
		h_cur    = dim_at(h0_q, k_q);
		lvl_act  = (k_q < LVL_W'(MAX_LEVELS)) &&
			((w_cur > DIM_W'(1)) || (h_cur > DIM_W'(1)));
		w_one    = (w_cur == DIM_W'(1));
		h_one    = (h_cur == DIM_W'(1));
		c_cur    = col_cnt_q[k_q];
		r_cur    = row_cnt_q[k_q];
		c_last   = (DIM_W'(c_cur) + DIM_W'(1)) >= w_cur;
		r_last   = (DIM_W'(r_cur) + DIM_W'(1)) >= h_cur;
		hold_cur = hold_q[k_q];
		// a width of one pairs the pixel with itself
		if (w_one) begin
			pair_cur.b = {pix_q.blue, 1'b0};
			pair_cur.g = {pix_q.green, 1'b0};
			pair_cur.r = {pix_q.red, 1'b0};
			pair_cur.a = {pix_q.alpha, 1'b0};
		end else begin
			pair_cur.b = {1'b0, hold_cur.blue} + {1'b0, pix_q.blue};
			pair_cur.g = {1'b0, hold_cur.green} + {1'b0, pix_q.green};
			pair_cur.r = {1'b0, hold_cur.red} + {1'b0, pix_q.red};
			pair_cur.a = {1'b0, hold_cur.alpha} + {1'b0, pix_q.alpha};
		end
		h_go    = w_one || c_cur[0];
		v_go    = h_one || r_cur[0];
		tx_cur  = w_one ? '0 : (c_cur >> 1);
		idx     = off_q + ADDR_W'(tx_cur);
		hold_wr = (state_q == ST_HORZ) && lvl_act && !h_go && !c_last;
		mem_wr  = (state_q == ST_HORZ) && lvl_act && h_go && !v_go && !r_last;
	end

	// ------------------------------------------------------------ vertical
	tot_t             tot;
	pix_t             mean;
	logic [LVL_W-1:0] k_nxt;
	logic [DIM_W-1:0] w_nxt, h_nxt;
	logic             nxt_act, done, out_free, out_load;

	always_comb begin
		if (hone_q) begin
			tot.b = {pair_q.b, 1'b0};
			tot.g = {pair_q.g, 1'b0};
			tot.r = {pair_q.r, 1'b0};
			tot.a = {pair_q.a, 1'b0};
		end else begin
			tot.b = {1'b0, mem_rd_q.b} + {1'b0, pair_q.b};
			tot.g = {1'b0, mem_rd_q.g} + {1'b0, pair_q.g};
			tot.r = {1'b0, mem_rd_q.r} + {1'b0, pair_q.r};
			tot.a = {1'b0, mem_rd_q.a} + {1'b0, pair_q.a};
		end
		mean.blue  = round_mean(tot.b);
		mean.green = round_mean(tot.g);
		mean.red   = round_mean(tot.r);
		mean.alpha = round_mean(tot.a);
		k_nxt   = k_q + LVL_W'(1);
		w_nxt   = dim_at(w0_q, k_nxt);
		h_nxt   = dim_at(h0_q, k_nxt);
		nxt_act = (k_nxt < LVL_W'(MAX_LEVELS)) &&
			((w_nxt > DIM_W'(1)) || (h_nxt > DIM_W'(1)));
		done    = !nxt_act &&
			((DIM_W'(tx_q) + DIM_W'(1)) == w_nxt) &&
			((DIM_W'(ty_q) + DIM_W'(1)) == h_nxt);
		out_free = !out_valid_q || m_axis_tready;
		out_load = (state_q == ST_VERT) && out_free;
	end

	// ------------------------------------------------------------ sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			w0_q        <= DIM_W'(1);
			h0_q        <= DIM_W'(1);
			k_q         <= '0;
			off_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NLVL; i++) begin
				col_cnt_q[i] <= '0;
				row_cnt_q[i] <= '0;
			end
		end else begin
			// load a new result or drop the one just taken
			out_valid_q <= out_load || (out_valid_q && !m_axis_tready);
			if (cfg_wr) begin
				// restart the image on any geometry write
				if (cfg_index == REG_BASE_WIDTH) begin
					w0_q <= cfg_dim;
				end else if (cfg_index == REG_BASE_HEIGHT) begin
					h0_q <= cfg_dim;
				end
				if (cfg_index == REG_BASE_WIDTH || cfg_index == REG_BASE_HEIGHT) begin
					for (int i = 0; i < NLVL; i++) begin
						col_cnt_q[i] <= '0;
						row_cnt_q[i] <= '0;
					end
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						k_q     <= '0;
						off_q   <= '0;
						state_q <= ST_HORZ;
					end
				end
				ST_HORZ: begin
					if (!lvl_act) begin
						state_q <= ST_IDLE;
					end else begin
						// advance this level's raster position, wrap at image end
						if (c_last) begin
							col_cnt_q[k_q] <= '0;
							row_cnt_q[k_q] <= r_last ? '0 : r_cur + CNT_W'(1);
						end else begin
							col_cnt_q[k_q] <= c_cur + CNT_W'(1);
						end
						if (h_go && v_go)
							state_q <= ST_VERT;
						else
							state_q <= ST_IDLE;
					end
				end
				ST_VERT: begin
					if (out_free) begin
						off_q       <= off_q + ADDR_W'(w_nxt);
						k_q         <= k_nxt;
						state_q     <= ST_HORZ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid)
			pix_q <= pix_t'(s_axis_tdata);
		if (state_q == ST_HORZ) begin
			pair_q <= pair_cur;
			tx_q   <= tx_cur;
			ty_q   <= h_one ? '0 : (r_cur >> 1);
			hone_q <= h_one;
		end
		if (hold_wr)
			hold_q[k_q] <= pix_q;
		if (state_q == ST_VERT && out_free) begin
			pix_q       <= mean;                // feed the next level
			out_level_q <= LEVEL_W'(k_nxt);
			out_col_q   <= POS_W'(tx_q);
			out_row_q   <= POS_W'(ty_q);
			out_pix_q   <= mean;
			out_last_q  <= done;
		end
	end

	// pair row memory: a write and a registered read, both in the horizontal
	// step; hold the read data through a stalled vertical step
	always_ff @(posedge clk) begin
		if (mem_wr)
			pair_mem[idx] <= pair_cur;
		if (state_q == ST_HORZ)
			mem_rd_q <= pair_mem[idx];
	end

	// ------------------------------------------------------------ ports
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {PAD_W'(0), out_pix_q.alpha, out_pix_q.red,
		out_pix_q.green, out_pix_q.blue, out_row_q, out_col_q, out_level_q};

`ifndef SYNTHESIS
	// the vertical step only ever runs on a level inside the chain
	a_vert_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VERT) |-> (k_q < LVL_W'(MAX_LEVELS)))
		else $error("vertical step on a level past the chain");

	// an accepted pixel starts the walk at the top level
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_HORZ && k_q == '0))
		else $error("walk did not start at level zero");

	// emitted levels stay within the chain
	a_out_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_level_q != '0 && out_level_q <= LEVEL_W'(MAX_LEVELS)))
		else $error("emitted level out of range");
`endif

endmodule
